@@ rtl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg: shared types and codes for the compacting record table
// record layout, command codes, result status codes and cell controls
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int HEAD_W  = 64;
    localparam int TAIL_W  = 8;
    localparam int AGE_W   = 8;
    localparam int PHONE_W = 31;

    // command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_LISTED   = 3'd6;

    typedef struct packed {
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic [AGE_W-1:0]   age;
        logic [PHONE_W-1:0] phone;
    } t_rec;

    // per-cell controls: load from the input, or take the neighbor's record
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/crt_cell.sv @@
// ----------------------------------------------------------------------------
// crt_cell: one record slot of the table
// holds a record; loads a new one or takes its upper neighbor's record
// ----------------------------------------------------------------------------
module crt_cell (
    input  logic             i_clk,
    input  crt_pkg::t_cell_ctl i_ctl,
    input  crt_pkg::t_rec    i_load_rec,
    input  crt_pkg::t_rec    i_next_rec,
    output crt_pkg::t_rec    o_rec
);
    import crt_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.load) begin
            n_rec = i_load_rec;
        end else if (i_ctl.shift) begin
            n_rec = i_next_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

@@ rtl/compacting_record_table_core.sv @@
// ----------------------------------------------------------------------------
// compacting_record_table_core: ordered table of name/age/phone records
// append, search, compacting remove and list over a ring of record cells
// ----------------------------------------------------------------------------
// usage:
//   a command transfer happens on a clock edge with start high and busy low.
//   results come out on the o_ ports for one cycle each, marked by o_valid;
//   o_last flags the final result of the command. the receiver cannot stall,
//   every result is taken in the cycle it shows.
// command flow:
//   append, and any command on an empty table, answers in the cycle after the
//   transfer and busy stays low, so commands may follow back to back.
//   search, remove and list rotate the whole ring of CAPACITY cells once,
//   one position a cycle, comparing or reporting the record at cell 0;
//   list results stream out during the rotation, one per cycle. search and
//   remove answer from a closing state, in which remove also pulls the later
//   records down one slot. busy stays high through the rotation and, for
//   search and remove, the closing state; the next command waits until busy
//   falls.
// reset:
//   synchronous, active low; the table comes up empty. record cells are not
//   cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module compacting_record_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_command,
    input  logic [crt_pkg::HEAD_W-1:0]     i_key_head,
    input  logic [crt_pkg::TAIL_W-1:0]     i_key_tail,
    input  logic [crt_pkg::AGE_W-1:0]      i_age_in,
    input  logic [crt_pkg::PHONE_W-1:0]    i_phone_in,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [3:0]                     o_slot,
    output logic [crt_pkg::HEAD_W-1:0]     o_rec_head,
    output logic [crt_pkg::TAIL_W-1:0]     o_rec_tail,
    output logic [crt_pkg::AGE_W-1:0]      o_rec_age,
    output logic [crt_pkg::PHONE_W-1:0]    o_rec_phone,
    output logic [4:0]                     o_fill,
    output logic                           o_last
);
    import crt_pkg::*;

    // index width for a slot, count width able to hold CAPACITY itself
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state,  n_state;
    logic [1:0]      r_cmd,    n_cmd;
    logic [HEAD_W-1:0] r_key_head, n_key_head;
    logic [TAIL_W-1:0] r_key_tail, n_key_tail;
    logic [CW-1:0]   r_count,  n_count;
    logic [IW-1:0]   r_step,   n_step;
    logic            r_found,  n_found;
    logic [IW-1:0]   r_hit,    n_hit;
    t_rec            r_hit_rec, n_hit_rec;

    // registered result port
    logic            r_valid,  n_valid;
    logic [2:0]      r_status, n_status;
    logic [3:0]      r_slot,   n_slot;
    t_rec            r_out,    n_out;
    logic [4:0]      r_fill,   n_fill;
    logic            r_last,   n_last;

    // ring of record cells; cell k takes from cell k+1, the top wraps to 0
    t_rec      w_rec [CAPACITY];
    t_cell_ctl w_ctl [CAPACITY];
    t_rec      w_in_rec;

    // rotation pass: everything goes one place down, cell 0 wraps to the top
    logic      w_rotate;
    // compaction: cells from the removed slot upward take their neighbor
    logic      w_compact;

    assign w_in_rec = '{head: i_key_head, tail: i_key_tail,
                        age: i_age_in, phone: i_phone_in};

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            always_comb begin
                w_ctl[k].load  = r_state[0] && start && (i_command == CMD_APPEND)
                                 && (r_count != FULL_CNT)
                                 && (CW'(k) == r_count);
                w_ctl[k].shift = w_rotate || (w_compact && (IW'(k) >= r_hit));
            end

            crt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[k]),
                .i_load_rec (w_in_rec),
                .i_next_rec (w_rec[(k + 1) % CAPACITY]),
                .o_rec      (w_rec[k])
            );
        end
    endgenerate

    // the record under inspection sits in cell 0 during the rotation
    logic w_in_range;
    logic w_match;

    assign w_in_range = (CW'(r_step) < r_count);
    assign w_match    = w_in_range && !r_found
                        && (w_rec[0].head == r_key_head)
                        && (w_rec[0].tail == r_key_tail);

    assign w_rotate  = r_state[1];
    assign w_compact = r_state[2] && (r_cmd == CMD_REMOVE) && r_found;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key_head = r_key_head;
        n_key_tail = r_key_tail;
        n_count   = r_count;
        n_step    = r_step;
        n_found   = r_found;
        n_hit     = r_hit;
        n_hit_rec = r_hit_rec;

        n_valid  = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        n_out    = r_out;
        n_fill   = r_fill;
        n_last   = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_last = 1'b1;
                    n_fill = 5'(r_count);
                    n_slot = '0;
                    n_out  = '0;
                    if (i_command == CMD_APPEND) begin
                        n_valid = 1'b1;
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_APPENDED;
                            n_slot   = 4'(r_count);
                            n_out    = w_in_rec;
                            n_count  = r_count + CW'(1);
                            n_fill   = 5'(r_count + CW'(1));
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_EMPTY;
                    end else begin
                        // start a full rotation of the ring
                        n_cmd      = i_command;
                        n_key_head = i_key_head;
                        n_key_tail = i_key_tail;
                        n_step     = '0;
                        n_found    = 1'b0;
                        n_state    = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_cmd == CMD_LIST) begin
                    if (w_in_range) begin
                        n_valid  = 1'b1;
                        n_status = ST_LISTED;
                        n_slot   = 4'(r_step);
                        n_out    = w_rec[0];
                        n_fill   = 5'(r_count);
                        n_last   = ((CW'(r_step) + CW'(1)) == r_count);
                    end
                end else if (w_match) begin
                    n_found   = 1'b1;
                    n_hit     = r_step;
                    n_hit_rec = w_rec[0];
                end
                n_step = r_step + IW'(1);
                if (r_step == LAST_STEP) begin
                    // ring is back in its original order here
                    n_step  = '0;
                    n_state = (r_cmd == CMD_LIST) ? S_IDLE : S_DONE;
                end
            end

            S_DONE: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_fill  = 5'(r_count);
                if (!r_found) begin
                    n_status = ST_NOTFOUND;
                    n_slot   = '0;
                    n_out    = '0;
                end else begin
                    n_slot = 4'(r_hit);
                    n_out  = r_hit_rec;
                    if (r_cmd == CMD_REMOVE) begin
                        n_status = ST_REMOVED;
                        n_count  = r_count - CW'(1);
                        n_fill   = 5'(r_count - CW'(1));
                    end else begin
                        n_status = ST_FOUND;
                    end
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            r_valid <= n_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key_head <= n_key_head;
        r_key_tail <= n_key_tail;
        r_hit      <= n_hit;
        r_hit_rec  <= n_hit_rec;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_out      <= n_out;
        r_fill     <= n_fill;
        r_last     <= n_last;
    end

    assign busy        = !r_state[0];
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_rec_head  = r_out.head;
    assign o_rec_tail  = r_out.tail;
    assign o_rec_age   = r_out.age;
    assign o_rec_phone = r_out.phone;
    assign o_fill      = r_fill;
    assign o_last      = r_last;

endmodule

@@ rtl/crt_chk.sv @@
// ----------------------------------------------------------------------------
// crt_chk: port-level checks for the compacting record table
// watches the command and result ports over time
// ----------------------------------------------------------------------------
module crt_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic [4:0] o_fill,
    input logic       o_last
);
    import crt_pkg::*;

    // every accepted command either answers at once or keeps the block busy
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted command neither answered nor started work");

    // only list entries may be followed by more results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_LISTED) |-> o_last)
        else $error("single-result status without last");

    // empty table reports a zero fill
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_fill == 5'd0))
        else $error("empty status with nonzero fill");

    // an idle cycle without a command is never followed by a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !(start && !busy) |=> !o_valid)
        else $error("result without a command in flight");

endmodule

bind compacting_record_table_core crt_chk u_crt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_fill   (o_fill),
    .o_last   (o_last)
);

@@ verif/compacting_record_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// compacting_record_table_core_tb: self-checking bench for the record table
// drives append, search, remove and list commands over the start/busy
// handshake and follows the table in a shadow copy that predicts every result;
// each strobed result is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module compacting_record_table_core_tb;
    import crt_pkg::*;

    localparam int DEPTH = 16;

    // one result as the block reports it
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        t_rec       rec;
        logic [4:0] fill;
        logic       last;
    } t_table_result;

    // shadow of the table contents plus the results still owed by the block
    class record_table_shadow;
        t_rec          rows[$];
        t_table_result due_results[$];
        int unsigned   depth;
        int unsigned   mismatches;

        function new(int unsigned depth_i);
            depth = depth_i;
            mismatches = 0;
        endfunction

        // fill is the row count after the command has taken effect
        function void post(logic [2:0] status, int unsigned idx, t_rec rec, bit last);
            t_table_result r;
            r.status = status;
            r.slot   = 4'(idx);
            r.rec    = rec;
            r.fill   = 5'(rows.size());
            r.last   = last;
            due_results.push_back(r);
        endfunction

        // work out what one accepted command must produce
        function void apply_command(logic [1:0] cmd, t_rec rec);
            int   hit;
            t_rec blank;
            t_rec taken;
            blank = '0;
            hit = -1;
            if (cmd == CMD_APPEND) begin
                if (rows.size() >= depth) begin
                    post(ST_FULL, 0, blank, 1'b1);
                end else begin
                    rows.push_back(rec);
                    post(ST_APPENDED, rows.size() - 1, rec, 1'b1);
                end
            end else if (rows.size() == 0) begin
                post(ST_EMPTY, 0, blank, 1'b1);
            end else if (cmd == CMD_LIST) begin
                foreach (rows[i]) post(ST_LISTED, i, rows[i], i == rows.size() - 1);
            end else begin
                // first match from slot 0 up, all 72 name bits
                foreach (rows[i]) begin
                    if (hit < 0 && rows[i].head == rec.head && rows[i].tail == rec.tail)
                        hit = i;
                end
                if (hit < 0) begin
                    post(ST_NOTFOUND, 0, blank, 1'b1);
                end else if (cmd == CMD_SEARCH) begin
                    post(ST_FOUND, hit, rows[hit], 1'b1);
                end else begin
                    taken = rows[hit];
                    rows.delete(hit);
                    post(ST_REMOVED, hit, taken, 1'b1);
                end
            end
        endfunction

        function void flag(string what, t_table_result want, t_table_result seen);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: exp st=%0d slot=%0d head=%h tail=%h age=%h ph=%h fill=%0d last=%0b",
                         $time, what, want.status, want.slot, want.rec.head, want.rec.tail,
                         want.rec.age, want.rec.phone, want.fill, want.last);
            if (mismatches <= 10)
                $display("%0t %s: got st=%0d slot=%0d head=%h tail=%h age=%h ph=%h fill=%0d last=%0b",
                         $time, what, seen.status, seen.slot, seen.rec.head, seen.rec.tail,
                         seen.rec.age, seen.rec.phone, seen.fill, seen.last);
        endfunction

        function void match_result(t_table_result seen);
            t_table_result want;
            bit            same;
            if (due_results.size() == 0) begin
                flag("unexpected result", '0, seen);
            end else begin
                want = due_results.pop_front();
                same = want.status == seen.status && want.slot == seen.slot &&
                       want.rec.head == seen.rec.head && want.rec.tail == seen.rec.tail &&
                       want.rec.age == seen.rec.age && want.rec.phone == seen.rec.phone &&
                       want.fill == seen.fill && want.last == seen.last;
                if (!same) flag("result mismatch", want, seen);
            end
        endfunction

        // anything still owed at the end is a failure
        function void close_out();
            while (due_results.size() != 0)
                flag("missing result", due_results.pop_front(), '0);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [HEAD_W-1:0]  i_key_head;
    logic [TAIL_W-1:0]  i_key_tail;
    logic [AGE_W-1:0]   i_age_in;
    logic [PHONE_W-1:0] i_phone_in;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [3:0]         o_slot;
    logic [HEAD_W-1:0]  o_rec_head;
    logic [TAIL_W-1:0]  o_rec_tail;
    logic [AGE_W-1:0]   o_rec_age;
    logic [PHONE_W-1:0] o_rec_phone;
    logic [4:0]         o_fill;
    logic               o_last;

    record_table_shadow shadow = new(DEPTH);

    // steady stretches run with no gaps between commands
    bit          steady;
    logic [71:0] name_pool [6];

    compacting_record_table_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_key_head  (i_key_head),
        .i_key_tail  (i_key_tail),
        .i_age_in    (i_age_in),
        .i_phone_in  (i_phone_in),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_rec_head  (o_rec_head),
        .o_rec_tail  (o_rec_tail),
        .o_rec_age   (o_rec_age),
        .o_rec_phone (o_rec_phone),
        .o_fill      (o_fill),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: a strobed result is taken at the edge that ends its cycle,
    // so the values seen here are the ones held during that cycle
    always @(posedge i_clk) begin
        t_table_result seen;
        if (i_rst_n && o_valid) begin
            seen.status    = o_status;
            seen.slot      = o_slot;
            seen.rec.head  = o_rec_head;
            seen.rec.tail  = o_rec_tail;
            seen.rec.age   = o_rec_age;
            seen.rec.phone = o_rec_phone;
            seen.fill      = o_fill;
            seen.last      = o_last;
            shadow.match_result(seen);
        end
    end

    // zero padded name, byte 0 in the low bits of the head, byte 8 is the tail
    function automatic logic [71:0] name_key(string s);
        logic [71:0] key;
        key = '0;
        for (int i = 0; i < s.len() && i < 9; i++) begin
            if (i < 8) key[8 + 8*i +: 8] = s[i];
            else       key[7:0] = s[i];
        end
        return key;
    endfunction

    function automatic logic [71:0] random_name();
        logic [71:0] key;
        int          len;
        key = '0;
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            if (i < 8) key[8 + 8*i +: 8] = 8'($urandom_range(97, 122));
            else       key[7:0] = 8'($urandom_range(97, 122));
        end
        return key;
    endfunction

    function automatic int unsigned idle_gap();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // one command transfer; fields and start change only at a clock edge,
    // and start stays high into a back-to-back command
    task automatic issue(input logic [1:0] cmd, input logic [71:0] key,
                         input logic [7:0] age, input logic [30:0] phone);
        int unsigned gap;
        t_rec        rec;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command  <= cmd;
        i_key_head <= key[71:8];
        i_key_tail <= key[7:0];
        i_age_in   <= age;
        i_phone_in <= phone;
        start      <= 1'b1;
        // transfer happens at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        rec.head  = key[71:8];
        rec.tail  = key[7:0];
        rec.age   = age;
        rec.phone = phone;
        shadow.apply_command(cmd, rec);
    endtask

    // lookup-style command with random filler in the unused fields
    task automatic ask(input logic [1:0] cmd, input logic [71:0] key);
        issue(cmd, key, 8'($urandom()), 31'($urandom()));
    endtask

    // hold off until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge i_clk);
    endtask

    // pool of names reused so that searches and removes hit; one entry
    // differs from another only in the ninth byte
    task automatic refresh_pool();
        for (int i = 0; i < 3; i++) name_pool[i] = random_name();
        name_pool[3] = name_pool[0] ^ 72'h01;
        name_pool[4] = '1;
        name_pool[5] = {$urandom(), $urandom(), 8'($urandom())};
    endtask

    // random commands; percentages steer the table toward full or empty
    task automatic run_phase(input int n, input int append_pct,
                             input int remove_pct, input int list_pct);
        int          pick;
        logic [71:0] key;
        logic [1:0]  cmd;
        refresh_pool();
        for (int k = 0; k < n; k++) begin
            if (k % 20 == 0) steady = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < append_pct)                           cmd = CMD_APPEND;
            else if (pick < append_pct + remove_pct)         cmd = CMD_REMOVE;
            else if (pick < append_pct + remove_pct + list_pct) cmd = CMD_LIST;
            else                                             cmd = CMD_SEARCH;
            // mostly pool names, now and then a fully random key as noise
            if ($urandom_range(0, 9) == 0)
                key = {$urandom(), $urandom(), 8'($urandom())};
            else
                key = name_pool[$urandom_range(0, 5)];
            issue(cmd, key, 8'($urandom()), 31'($urandom()));
        end
    endtask

    initial begin
        logic [71:0] alice;
        logic [71:0] ninth;
        alice = name_key("alice");
        ninth = name_key("ninechars");
        steady     = 1'b0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_command  <= CMD_APPEND;
        i_key_head <= '0;
        i_key_tail <= '0;
        i_age_in   <= '0;
        i_phone_in <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table answers for list, search and remove
        ask(CMD_LIST, alice);
        ask(CMD_SEARCH, alice);
        ask(CMD_REMOVE, alice);
        // field extremes, a duplicate name and a full nine byte name
        issue(CMD_APPEND, '0, 8'h00, 31'h0);
        issue(CMD_APPEND, '1, 8'hff, 31'h7fffffff);
        issue(CMD_APPEND, alice, 8'd30, 31'd5551234);
        issue(CMD_APPEND, alice, 8'd31, 31'd5559876);
        issue(CMD_APPEND, ninth, 8'd77, 31'h2aaaaaaa);
        // first match wins, and one flipped tail bit must miss
        ask(CMD_SEARCH, alice);
        ask(CMD_SEARCH, {64'hffff_ffff_ffff_ffff, 8'hfe});
        ask(CMD_SEARCH, '0);
        ask(CMD_LIST, '0);
        // removes from the middle, the front and the end, with compaction
        ask(CMD_REMOVE, alice);
        ask(CMD_SEARCH, alice);
        ask(CMD_REMOVE, '0);
        ask(CMD_REMOVE, ninth);
        ask(CMD_LIST, '0);
        ask(CMD_REMOVE, '1);
        ask(CMD_REMOVE, ninth);
        ask(CMD_REMOVE, alice);
        ask(CMD_LIST, '0);
        ask(CMD_SEARCH, '1);
        drain();

        // random: fill past full, drain down, then mixed traffic; the pauses
        // between phases let every owed result come back first
        run_phase(35, 70, 10, 5);
        drain();
        run_phase(35, 20, 45, 10);
        drain();
        run_phase(35, 45, 25, 10);
        drain();
        run_phase(35, 65, 10, 10);
        drain();

        // a little settling time for any stray strobe
        repeat (DEPTH + 4) @(posedge i_clk);
        shadow.close_out();
        if (shadow.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/crt_pkg.sv
rtl/crt_cell.sv
rtl/compacting_record_table_core.sv
rtl/crt_chk.sv
verif/compacting_record_table_core_tb.sv
